@@ design/sptd_pkg.sv @@
// ----------------------------------------------------------------------------
// Small prime trial division package
// Shared types, the list of odd small primes and elaboration-time helpers.
// ----------------------------------------------------------------------------
package sptd_pkg;

   localparam int NUM_PRIMES = 19;
   localparam int PRIMES [NUM_PRIMES] = '{
      3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 43, 47, 53, 59, 61, 67, 71
   };

   localparam int VERDICT_W = 2;
   localparam int RSP_DATA_W = 8;

   localparam logic [VERDICT_W-1:0] VERDICT_DIVISIBLE = 2'd0;
   localparam logic [VERDICT_W-1:0] VERDICT_PASSED    = 2'd1;
   localparam logic [VERDICT_W-1:0] VERDICT_PRIME     = 2'd2;

   // Pipeline control that the top level hands to every cell.
   typedef struct packed {
      logic advance;
      logic update;
      logic last;
   } pipe_ctl_type;

   // Flags that ripple from one cell to the next.
   typedef struct packed {
      logic divisible;
      logic equal;
   } chain_type;

   // 2^k mod q, evaluated during elaboration.
   function automatic int pow2_mod(input int k, input int q);
      int r;
      r = 1;
      for (int i = 0; i < k; i++) begin
         r = r * 2;
         if (r >= q) begin
            r = r - q;
         end
      end
      return r;
   endfunction

endpackage

@@ design/sptd_cell.sv @@
// ----------------------------------------------------------------------------
// Small prime trial division cell
// Keeps the running residue of the candidate for one prime and passes the
// divisibility and equality flags on to its neighbor.
// ----------------------------------------------------------------------------
module sptd_cell #(
   parameter int WORD_BITS = 32,
   parameter int Q = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  sptd_pkg::pipe_ctl_type ctl,
   input  logic [WORD_BITS-1:0]   word,
   input  logic                   up_zero,
   input  sptd_pkg::chain_type    chain_in,
   output sptd_pkg::chain_type    chain_out
);
   import sptd_pkg::*;

   localparam int RW = $clog2(Q);
   localparam int NCH = (WORD_BITS + 7) / 8;
   localparam int PAD_W = NCH * 8;
   localparam int SUM_W = $clog2(NCH * 255 * (Q - 1) + 1);
   localparam int SHIFT = SUM_W + RW;
   localparam int PROD_W = SUM_W + SHIFT;
   localparam longint unsigned MUL = ((longint'(1) << SHIFT) + Q - 1) / Q;
   localparam int P2W = pow2_mod(WORD_BITS, Q);

   logic [PAD_W-1:0]  word_pad;
   logic [SUM_W-1:0]  part [NCH];
   logic [SUM_W-1:0]  x_sum;
   logic [RW-1:0]     tbl [Q];
   logic [PROD_W-1:0] prod;
   logic [SUM_W-1:0]  rem_full;
   logic [RW:0]       r_sum;
   logic [RW-1:0]     r_next;

   logic [SUM_W-1:0]  x_ff, x2_ff, t_ff;
   logic [RW-1:0]     s_ff, r_ff;
   logic              eq1_ff, eq2_ff, eq3_ff;

   assign word_pad = PAD_W'(word);

   for (genvar k = 0; k < NCH; k++) begin : g_chunk
      localparam int CW = pow2_mod(8 * k, Q);
      assign part[k] = SUM_W'(word_pad[k*8 +: 8]) * SUM_W'(CW);
   end

   for (genvar j = 0; j < Q; j++) begin : g_tbl
      localparam int TV = (j * P2W) % Q;
      assign tbl[j] = RW'(TV);
   end

   always_comb begin
      x_sum = '0;
      for (int k = 0; k < NCH; k++) begin
         x_sum = x_sum + part[k];
      end
   end

   assign prod = PROD_W'(x_ff) * PROD_W'(MUL);
   assign rem_full = x2_ff - t_ff * SUM_W'(Q);

   assign r_sum = (RW+1)'(tbl[r_ff]) + (RW+1)'(s_ff);
   assign r_next = (r_sum >= (RW+1)'(Q)) ? RW'(r_sum - (RW+1)'(Q)) : RW'(r_sum);

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         x_ff   <= x_sum;
         eq1_ff <= up_zero && (word == WORD_BITS'(Q));
         x2_ff  <= x_ff;
         t_ff   <= prod[PROD_W-1:SHIFT];
         eq2_ff <= eq1_ff;
         s_ff   <= rem_full[RW-1:0];
         eq3_ff <= eq2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_ff <= '0;
      end else if (ctl.update) begin
         r_ff <= ctl.last ? '0 : r_next;
      end
   end

   assign chain_out.divisible = chain_in.divisible | (r_next == '0);
   assign chain_out.equal     = chain_in.equal | eq3_ff;

endmodule

@@ design/small_prime_trial_division.sv @@
// ----------------------------------------------------------------------------
// Small prime trial division
// Sieves a multiprecision candidate against the odd primes from 3 to 71.
// ----------------------------------------------------------------------------
// The candidate arrives on the req_ channel one word per request, most
// significant word first, with req_tlast on the least significant word.
// Each word updates a residue in every one of 19 cells, one cell per prime.
// After the last word one response is sent on the rsp_ channel:
//    0 when a listed prime divides the candidate (zero included),
//    1 when the candidate passes the sieve,
//    2 when the candidate equals one of the listed primes.
// A word is accepted every cycle while the response side keeps up, so the
// throughput is one word per cycle. Inside each cell the word is reduced in
// three pipeline stages before it meets the residue register, and the
// verdict is registered once more before it is sent on the rsp_ channel.
// While a response waits for rsp_tready the whole pipeline holds and
// req_tready is low. Reset clears all residues and valid flags, after which
// the next word starts a new candidate.
// ----------------------------------------------------------------------------
module small_prime_trial_division #(
   parameter int WORD_BITS = 32
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         req_tvalid,
   output logic                                         req_tready,
   // Bits from the lowest up: word.
   input  logic [((WORD_BITS+7)/8)*8-1:0]               req_tdata,
   input  logic                                         req_tlast,
   output logic                                         rsp_tvalid,
   input  logic                                         rsp_tready,
   // Bits from the lowest up: verdict, then zero fill.
   output logic [sptd_pkg::RSP_DATA_W-1:0]              rsp_tdata
);
   import sptd_pkg::*;

   logic                  advance;
   logic                  accept;
   logic [WORD_BITS-1:0]  word;
   pipe_ctl_type          ctl;
   chain_type             chain [NUM_PRIMES+1];
   logic [VERDICT_W-1:0]  verdict_in;

   logic v1_ff, v2_ff, v3_ff;
   logic last1_ff, last2_ff, last3_ff;
   logic un_ff, un_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [VERDICT_W-1:0] verdict_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;
   assign word       = req_tdata[WORD_BITS-1:0];

   assign ctl.advance = advance;
   assign ctl.update  = advance && v3_ff;
   assign ctl.last    = last3_ff;

   assign chain[0] = '0;

   for (genvar i = 0; i < NUM_PRIMES; i++) begin : g_cell
      sptd_cell #(
         .WORD_BITS(WORD_BITS),
         .Q        (PRIMES[i])
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .word     (word),
         .up_zero  (!un_ff),
         .chain_in (chain[i]),
         .chain_out(chain[i+1])
      );
   end

   assign un_in = req_tlast ? 1'b0 : (un_ff || (word != '0));

   always_comb begin
      priority if (chain[NUM_PRIMES].equal) begin
         verdict_in = VERDICT_PRIME;
      end else if (chain[NUM_PRIMES].divisible) begin
         verdict_in = VERDICT_DIVISIBLE;
      end else begin
         verdict_in = VERDICT_PASSED;
      end
   end

   assign rsp_valid_in = v3_ff && last3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         un_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            v1_ff        <= accept;
            v2_ff        <= v1_ff;
            v3_ff        <= v2_ff;
            rsp_valid_ff <= rsp_valid_in;
         end
         if (accept) begin
            un_ff <= un_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last1_ff   <= req_tlast;
         last2_ff   <= last1_ff;
         last3_ff   <= last2_ff;
         verdict_ff <= verdict_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_W'(verdict_ff);

endmodule

@@ verif/tb_small_prime_trial_division.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Small prime trial division testbench
// Streams multiword candidates into the sieve and compares every verdict
// against residues that the testbench tracks itself, with random idling on
// the request side and a random stall pattern on the response side.
// ----------------------------------------------------------------------------
module tb_small_prime_trial_division;

   import sptd_pkg::*;

   localparam int WORD_BITS = 32;
   localparam int DRAIN_CYCLES = 20;
   localparam int WORD_TARGET = 1250;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_RARE
   } ready_mode_type;

   typedef enum int {
      CAND_RANDOM,
      CAND_LISTED_PRIME,
      CAND_MULTIPLE,
      CAND_SMALL_TAIL,
      CAND_ZERO
   } cand_kind_type;

   class verdict_scoreboard_type;
      logic [6:0] residue [NUM_PRIMES];
      bit upper_nonzero;
      logic [VERDICT_W-1:0] expected_verdicts [$];
      int errors;

      function new();
         errors = 0;
         clear_candidate();
      endfunction

      function void clear_candidate();
         foreach (residue[i]) begin
            residue[i] = '0;
         end
         upper_nonzero = 1'b0;
      endfunction

      function void note_word(logic [WORD_BITS-1:0] word, logic last);
         longint unsigned acc;
         bit equal;
         bit divisible;
         equal = 1'b0;
         divisible = 1'b0;
         for (int i = 0; i < NUM_PRIMES; i++) begin
            acc = {25'd0, residue[i], word};
            residue[i] = 7'(acc % longint'(PRIMES[i]));
            if (residue[i] == 0) begin
               divisible = 1'b1;
            end
            if (!upper_nonzero && word == WORD_BITS'(PRIMES[i])) begin
               equal = 1'b1;
            end
         end
         if (!last) begin
            if (word != 0) begin
               upper_nonzero = 1'b1;
            end
         end else begin
            if (equal) begin
               expected_verdicts.push_back(VERDICT_PRIME);
            end else if (divisible) begin
               expected_verdicts.push_back(VERDICT_DIVISIBLE);
            end else begin
               expected_verdicts.push_back(VERDICT_PASSED);
            end
            clear_candidate();
         end
      endfunction

      function void check_verdict(logic [VERDICT_W-1:0] actual);
         logic [VERDICT_W-1:0] exp_verdict;
         if (expected_verdicts.size() == 0) begin
            $error("verdict: expected none, actual %0d", actual);
            errors++;
         end else begin
            exp_verdict = expected_verdicts.pop_front();
            if (actual !== exp_verdict) begin
               $error("verdict: expected %0d, actual %0d", exp_verdict, actual);
               errors++;
            end
         end
      endfunction

      function int pending();
         return expected_verdicts.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [WORD_BITS-1:0] req_tdata = '0;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   verdict_scoreboard_type sb = new();
   int burst_left = 0;
   int words_sent = 0;
   ready_mode_type ready_mode = READY_ALWAYS;
   int ready_mode_left = 0;

   small_prime_trial_division #(
      .WORD_BITS(WORD_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (ready_mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 2));
         ready_mode_left = $urandom_range(20, 200);
      end else begin
         ready_mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS: begin
            rsp_tready <= 1'b1;
         end
         READY_COIN: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 7) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_word(req_tdata, req_tlast);
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_verdict(rsp_tdata[VERDICT_W-1:0]);
         end
      end
   end

   task automatic send_word(input logic [WORD_BITS-1:0] word, input logic last);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 8);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      req_tlast <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   task automatic wait_all_verdicts();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
   endtask

   initial begin
      #2_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      cand_kind_type kind;
      int len;
      int pick;
      int prime_pick;
      int cand_count;
      logic [WORD_BITS-1:0] word;
      logic last;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      send_word(32'd0, 1'b1);
      send_word(32'd1, 1'b1);
      send_word(32'd2, 1'b1);
      send_word(32'd3, 1'b1);
      send_word(32'd5, 1'b1);
      send_word(32'd71, 1'b1);
      send_word(32'd73, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'd4294967291, 1'b1);
      send_word(32'd215656441, 1'b1);
      send_word(32'd95041567, 1'b1);
      send_word(32'd907383479, 1'b1);
      send_word(32'd0, 1'b0);
      send_word(32'd0, 1'b0);
      send_word(32'd71, 1'b1);
      send_word(32'd1, 1'b0);
      send_word(32'd71, 1'b1);
      send_word(32'hFFFF_FFFF, 1'b0);
      send_word(32'hFFFF_FFFF, 1'b1);
      send_word(32'h8000_0000, 1'b0);
      send_word(32'd0, 1'b1);
      send_word(32'd0, 1'b0);
      send_word(32'd0, 1'b1);
      wait_all_verdicts();

      cand_count = 0;
      while (words_sent < WORD_TARGET) begin
         pick = $urandom_range(0, 15);
         if (pick < 7) begin
            kind = CAND_RANDOM;
         end else if (pick < 9) begin
            kind = CAND_LISTED_PRIME;
         end else if (pick < 12) begin
            kind = CAND_MULTIPLE;
         end else if (pick < 15) begin
            kind = CAND_SMALL_TAIL;
         end else begin
            kind = CAND_ZERO;
         end
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
         prime_pick = PRIMES[$urandom_range(0, NUM_PRIMES - 1)];
         for (int k = 0; k < len; k++) begin
            last = (k == len - 1);
            case (kind)
               CAND_LISTED_PRIME: begin
                  word = last ? WORD_BITS'(prime_pick) : '0;
               end
               CAND_MULTIPLE: begin
                  if (last) begin
                     word = WORD_BITS'(prime_pick)
                            * $urandom_range(0, 32'hFFFF_FFFF / prime_pick);
                  end else begin
                     word = ($urandom_range(0, 2) == 0) ? $urandom : '0;
                  end
               end
               CAND_SMALL_TAIL: begin
                  if (last) begin
                     word = $urandom_range(0, 80);
                  end else begin
                     word = ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(1, 3);
                  end
               end
               CAND_ZERO: begin
                  word = '0;
               end
               default: begin
                  word = ($urandom_range(0, 7) == 0) ? '0 : $urandom;
               end
            endcase
            send_word(word, last);
         end
         cand_count++;
         if (cand_count % 200 == 0) begin
            wait_all_verdicts();
         end
      end

      wait_all_verdicts();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/sptd_pkg.sv
design/sptd_cell.sv
design/small_prime_trial_division.sv
verif/tb_small_prime_trial_division.sv
